[rtl/ps2mct_pkg.sv]
// Shared types and constants for the PS/2 mouse packet cursor tracker.
// No dependencies; every other file of the block but ps2mct_obuf imports this package.
package ps2mct_pkg;

  localparam int BYTE_W    = 8;
  localparam int LIMIT_W   = 10;
  localparam int BTN_W     = 3;
  localparam int WHEEL_W   = 4;
  localparam int CFG_IDX_W = 2;

  // Bit positions inside the first byte of a packet
  localparam int HEAD_SYNC_BIT = 3;
  localparam int X_SIGN_BIT    = 4;
  localparam int Y_SIGN_BIT    = 5;

  // Reset values
  localparam logic [LIMIT_W-1:0] X_LIMIT_RST = LIMIT_W'(317);
  localparam logic [LIMIT_W-1:0] Y_LIMIT_RST = LIMIT_W'(249);
  localparam int POS_X_RST = 150;
  localparam int POS_Y_RST = 120;

  // Action codes of an input beat
  localparam logic ACT_BYTE    = 1'b0;
  localparam logic ACT_TIMEOUT = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WHEEL_MODE = 2'd0,
    CFG_X_LIMIT    = 2'd1,
    CFG_Y_LIMIT    = 2'd2
  } cfg_idx_t;

  // Packet byte position, one-hot
  typedef enum logic [3:0] {
    ST_HEAD  = 4'b0001,
    ST_DX    = 4'b0010,
    ST_DY    = 4'b0100,
    ST_WHEEL = 4'b1000
  } pkt_state_t;

  // Configuration seen by the packet datapath
  typedef struct packed {
    logic               wheel_mode;
    logic [LIMIT_W-1:0] x_limit;
    logic [LIMIT_W-1:0] y_limit;
  } cfg_t;

endpackage

[rtl/ps2mct_cfg.sv]
// Configuration register file of the PS/2 mouse cursor tracker.
// Depends on ps2mct_pkg for the register indexes and the cfg_t struct.
module ps2mct_cfg (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [ps2mct_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ps2mct_pkg::LIMIT_W-1:0]         cfg_data,
  output ps2mct_pkg::cfg_t                       cfg_o
);
  import ps2mct_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  // Always ready: a write is registered in cfg_r
  assign cfg_ready = 1'b1;

  // Decode the register index; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WHEEL_MODE: cfg_nxt.wheel_mode = cfg_data[0];
        CFG_X_LIMIT:    cfg_nxt.x_limit    = cfg_data;
        CFG_Y_LIMIT:    cfg_nxt.y_limit    = cfg_data;
        default:        cfg_nxt            = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wheel_mode <= 1'b0;
      cfg_r.x_limit    <= X_LIMIT_RST;
      cfg_r.y_limit    <= Y_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

[rtl/ps2mct_asm.sv]
// Packet assembly and cursor update of the PS/2 mouse cursor tracker.
// Depends on ps2mct_pkg; consumes one beat per cycle and flags a finished packet.
module ps2mct_asm #(
  parameter int POS_WIDTH = 10
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 beat_i,
  input  logic                                 action_i,
  input  logic [ps2mct_pkg::BYTE_W-1:0]        rx_byte_i,
  input  ps2mct_pkg::cfg_t                     cfg_i,
  output logic                                 res_valid_o,
  output logic [ps2mct_pkg::BTN_W-1:0]         res_buttons_o,
  output logic [POS_WIDTH-1:0]                 res_x_o,
  output logic [POS_WIDTH-1:0]                 res_y_o,
  output logic [ps2mct_pkg::WHEEL_W-1:0]       res_wheel_o
);
  import ps2mct_pkg::*;

  // Signed working width: covers the position, the limit and a 9-bit delta
  localparam int SW = ((POS_WIDTH > LIMIT_W) ? POS_WIDTH : LIMIT_W) + 2;
  localparam logic signed [SW-1:0] PosMax = {{(SW-POS_WIDTH){1'b0}}, {POS_WIDTH{1'b1}}};

  pkt_state_t          state_r, state_nxt;
  logic [BYTE_W-1:0]   head_r, head_nxt;
  logic [BYTE_W-1:0]   dx_r, dx_nxt;
  logic [BYTE_W-1:0]   dy_r, dy_nxt;
  logic [POS_WIDTH-1:0] pos_x_r, pos_x_nxt;
  logic [POS_WIDTH-1:0] pos_y_r, pos_y_nxt;
  logic [WHEEL_W-1:0]  wheel_r, wheel_nxt;
  logic [BTN_W-1:0]    btn_r, btn_nxt;

  logic                finish;
  logic [BYTE_W-1:0]   dy_src;
  logic signed [8:0]   dx9, dy9;
  logic signed [SW-1:0] sum_x, sum_y;
  logic [POS_WIDTH-1:0] new_x, new_y;

  function automatic logic [POS_WIDTH-1:0] clamp_pos(input logic signed [SW-1:0] v,
                                                    input logic [LIMIT_W-1:0] lim);
    logic signed [SW-1:0] hi;
    logic signed [SW-1:0] c;
    begin
      hi = signed'(SW'(lim));
      if (hi > PosMax) hi = PosMax;
      c = v;
      if (c < 0)  c = '0;
      if (c > hi) c = hi;
      return c[POS_WIDTH-1:0];
    end
  endfunction

  // Deltas: the third byte may be arriving in this very beat
  assign dy_src = (state_r == ST_DY) ? rx_byte_i : dy_r;
  assign dx9    = signed'({head_r[X_SIGN_BIT], dx_r});
  assign dy9    = signed'({head_r[Y_SIGN_BIT], dy_src});
  assign sum_x  = signed'(SW'(pos_x_r)) + SW'(dx9);
  assign sum_y  = signed'(SW'(pos_y_r)) - SW'(dy9);
  assign new_x  = clamp_pos(sum_x, cfg_i.x_limit);
  assign new_y  = clamp_pos(sum_y, cfg_i.y_limit);

  // Advance the packet state on each beat
  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    wheel_nxt = wheel_r;
    btn_nxt   = btn_r;
    finish    = 1'b0;
    if (beat_i) begin
      if (action_i == ACT_TIMEOUT) begin
        // drop any partial packet
        state_nxt = ST_HEAD;
      end else begin
        unique case (state_r)
          ST_HEAD: begin
            if (rx_byte_i[HEAD_SYNC_BIT]) begin
              head_nxt  = rx_byte_i;
              state_nxt = ST_DX;
            end
          end
          ST_DX: begin
            dx_nxt    = rx_byte_i;
            state_nxt = ST_DY;
          end
          ST_DY: begin
            dy_nxt = rx_byte_i;
            if (cfg_i.wheel_mode) begin
              state_nxt = ST_WHEEL;
            end else begin
              finish    = 1'b1;
              state_nxt = ST_HEAD;
            end
          end
          ST_WHEEL: begin
            finish    = 1'b1;
            wheel_nxt = wheel_r + rx_byte_i[WHEEL_W-1:0];
            state_nxt = ST_HEAD;
          end
          default: state_nxt = ST_HEAD;
        endcase
        if (finish) begin
          btn_nxt   = head_r[BTN_W-1:0];
          pos_x_nxt = new_x;
          pos_y_nxt = new_y;
        end
      end
    end
  end

  // Control state and cursor state are reset; captured bytes are not
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HEAD;
      pos_x_r <= POS_WIDTH'(POS_X_RST);
      pos_y_r <= POS_WIDTH'(POS_Y_RST);
      wheel_r <= '0;
      btn_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      wheel_r <= wheel_nxt;
      btn_r   <= btn_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
  end

  // Result of the beat that closes a packet
  assign res_valid_o   = finish;
  assign res_buttons_o = btn_nxt;
  assign res_x_o       = pos_x_nxt;
  assign res_y_o       = pos_y_nxt;
  assign res_wheel_o   = wheel_nxt;

endmodule

[rtl/ps2mct_obuf.sv]
// Result register with a skid stage for the PS/2 mouse cursor tracker.
// Generic over payload width; no package dependency.
module ps2mct_obuf #(
  parameter int WIDTH = 27
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [WIDTH-1:0] out_data
);

  logic             main_valid_r, main_valid_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  logic [WIDTH-1:0] main_r, main_nxt;
  logic [WIDTH-1:0] skid_r, skid_nxt;
  logic             pop;

  assign pop = main_valid_r && !out_stall;

  // Move beats: skid refills the output register, new beats fill the first free slot
  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (pop) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end else if (push_i) begin
        main_nxt = push_data_i;
      end else begin
        main_valid_nxt = 1'b0;
      end
    end else if (push_i) begin
      if (!main_valid_r) begin
        main_nxt       = push_data_i;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_data_i;
        skid_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign full_o    = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

endmodule

[rtl/ps2_mouse_packet_cursor_tracker_core.sv]
// PS/2 mouse packet decoder with cursor tracking. Each input beat is a received
// mouse byte or a receive-gap timeout; the block takes one beat per clock cycle
// while in_stall is low and emits one result beat (buttons, clamped cursor X/Y,
// wheel count) for every complete 3-byte packet, or 4-byte packet in wheel mode.
// The result is registered in the output buffer when the closing byte is accepted.
// A result register plus one skid entry sit on the output, so beats keep flowing
// while one result waits; in_stall rises only when both entries hold undelivered
// results. Configuration writes are registered (cfg_ready is always high) and
// belong in idle time. Depends on ps2mct_pkg, ps2mct_cfg, ps2mct_asm and ps2mct_obuf.
module ps2_mouse_packet_cursor_tracker_core #(
  parameter int POS_WIDTH = 10
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_action,
  input  logic [ps2mct_pkg::BYTE_W-1:0]        in_rx_byte,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [ps2mct_pkg::BTN_W-1:0]         out_buttons,
  output logic [POS_WIDTH-1:0]                 out_cursor_x,
  output logic [POS_WIDTH-1:0]                 out_cursor_y,
  output logic [ps2mct_pkg::WHEEL_W-1:0]       out_wheel_count,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ps2mct_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ps2mct_pkg::LIMIT_W-1:0]       cfg_data
);
  import ps2mct_pkg::*;

  localparam int RES_W = BTN_W + 2 * POS_WIDTH + WHEEL_W;

  cfg_t                 cfg;
  logic                 beat;
  logic                 res_valid;
  logic [BTN_W-1:0]     res_buttons;
  logic [POS_WIDTH-1:0] res_x;
  logic [POS_WIDTH-1:0] res_y;
  logic [WHEEL_W-1:0]   res_wheel;
  logic                 obuf_full;
  logic [RES_W-1:0]     out_data;

  assign beat     = in_valid && !in_stall;
  assign in_stall = obuf_full;

  ps2mct_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  ps2mct_asm #(.POS_WIDTH(POS_WIDTH)) u_asm (
    .clk           (clk),
    .rst_n         (rst_n),
    .beat_i        (beat),
    .action_i      (in_action),
    .rx_byte_i     (in_rx_byte),
    .cfg_i         (cfg),
    .res_valid_o   (res_valid),
    .res_buttons_o (res_buttons),
    .res_x_o       (res_x),
    .res_y_o       (res_y),
    .res_wheel_o   (res_wheel)
  );

  ps2mct_obuf #(.WIDTH(RES_W)) u_obuf (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (res_valid),
    .push_data_i ({res_buttons, res_x, res_y, res_wheel}),
    .full_o      (obuf_full),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  // Unpack the result beat
  assign out_buttons     = out_data[RES_W-1 -: BTN_W];
  assign out_cursor_x    = out_data[WHEEL_W + 2*POS_WIDTH - 1 -: POS_WIDTH];
  assign out_cursor_y    = out_data[WHEEL_W + POS_WIDTH - 1 -: POS_WIDTH];
  assign out_wheel_count = out_data[WHEEL_W-1:0];

endmodule

[rtl/ps2mct_chk.sv]
// Port-level checks for the PS/2 mouse cursor tracker, bound to the top level.
// Depends on ps2mct_pkg for field widths.
module ps2mct_chk #(
  parameter int POS_WIDTH = 10
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic [ps2mct_pkg::BTN_W-1:0]         out_buttons,
  input logic [POS_WIDTH-1:0]                 out_cursor_x,
  input logic [POS_WIDTH-1:0]                 out_cursor_y,
  input logic [ps2mct_pkg::WHEEL_W-1:0]       out_wheel_count,
  input logic                                 cfg_valid,
  input logic                                 cfg_ready
);
  import ps2mct_pkg::*;

  // Reset empties the output buffer
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  // Input back-pressure only while a result is waiting
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("in_stall without a pending result");

  // Config port never blocks
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("cfg_ready low on a write");

  // Stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // Stalled result payload holds
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_cursor_x) && $stable(out_cursor_y)
      && $stable(out_buttons) && $stable(out_wheel_count))
    else $error("result payload changed while stalled");

endmodule

bind ps2_mouse_packet_cursor_tracker_core ps2mct_chk #(.POS_WIDTH(POS_WIDTH)) u_chk (.*);
